>>> rtl/tmce_pkg.sv
package tmce_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_SETC  = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // Control characters.
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [3:0] {
      K_PRINT,
      K_BKSP,
      K_NEWLINE,
      K_RETURN,
      K_TAB,
      K_CLEAR,
      K_SETCUR,
      K_REJECT,
      K_READ,
      K_READ_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
      logic [7:0]   attr;
      logic [6:0]   tcol;
      logic [4:0]   trow;
      logic [10:0]  ridx;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

>>> rtl/text_mode_console_engine_unit.sv
// Channel | Direction | Handshake                | Payload
// req     | in        | req_tvalid / req_tready  | req_tdata, req_tuser (request kind)
// rsp     | out       | rsp_tvalid / rsp_tready  | rsp_tdata
// csr     | in        | csr_valid / csr_ready    | csr_data (clear attribute)
//
// A printable character goes through dequeue, cell write and result load.
// A tab writes spaces up to the next tab stop. A scroll moves every cell through
// the single write port of the cell store, and so does a clear screen.
// After reset the cell store is zeroed; requests queue meanwhile.
// A two-word queue lets requests be taken while the engine works or the result stalls.
module text_mode_console_engine_unit #(
   parameter int COLS     = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code, bg_color, fg_color, target_col, target_row, read_index
   input  logic [tmce_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_col, cursor_row, cursor_offset, cell_char, cell_attr, scrolled, rejected
   output logic [tmce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [7:0]                      csr_data
);

   tmce_pkg::queue_out_type q_out;
   logic                    q_pop;

   tmce_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_out      (q_out),
      .q_pop      (q_pop)
   );

   tmce_back #(.COLS(COLS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/tmce_front.sv
module tmce_front #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tmce_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   output tmce_pkg::queue_out_type             q_out,
   input  logic                                q_pop
);

   localparam int NCELLS = ROWS * COLS;

   tmce_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   tmce_pkg::cmd_type cmd;
   logic              push;

   always_comb begin
      cmd.ch   = req_tdata[7:0];
      cmd.attr = {req_tdata[11:8], req_tdata[15:12]};
      cmd.tcol = req_tdata[22:16];
      cmd.trow = req_tdata[27:23];
      cmd.ridx = req_tdata[38:28];
      unique case (req_tuser)
         tmce_pkg::REQ_PUT: begin
            case (req_tdata[7:0])
               tmce_pkg::CH_BACKSPACE: cmd.kind = tmce_pkg::K_BKSP;
               tmce_pkg::CH_NEWLINE:   cmd.kind = tmce_pkg::K_NEWLINE;
               tmce_pkg::CH_RETURN:    cmd.kind = tmce_pkg::K_RETURN;
               tmce_pkg::CH_TAB:       cmd.kind = tmce_pkg::K_TAB;
               default:                cmd.kind = tmce_pkg::K_PRINT;
            endcase
         end
         tmce_pkg::REQ_CLEAR: cmd.kind = tmce_pkg::K_CLEAR;
         tmce_pkg::REQ_SETC: begin
            if (32'(req_tdata[22:16]) < COLS && 32'(req_tdata[27:23]) < ROWS) begin
               cmd.kind = tmce_pkg::K_SETCUR;
            end else begin
               cmd.kind = tmce_pkg::K_REJECT;
            end
         end
         default: begin
            if (32'(req_tdata[38:28]) < NCELLS) begin
               cmd.kind = tmce_pkg::K_READ;
            end else begin
               cmd.kind = tmce_pkg::K_READ_NONE;
            end
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.cmd   = q_ff[rd_ptr_ff];

endmodule

>>> rtl/tmce_back.sv
module tmce_back #(
   parameter int COLS     = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tmce_pkg::queue_out_type             q_out,
   output logic                                q_pop,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [7:0]                          csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tmce_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int NCELLS = ROWS * COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int CW     = $clog2(COLS);
   localparam int RW     = $clog2(ROWS);
   localparam int COPY_N = NCELLS - COLS;

   typedef enum logic [7:0] {
      S_INIT   = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_PRINT  = 8'b0000_0100,
      S_BKWR   = 8'b0000_1000,
      S_SCROLL = 8'b0001_0000,
      S_SCRCLR = 8'b0010_0000,
      S_CLEAR  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   // Reads finish in S_DONE too: a read request waits there on rd_wait_ff
   // for the fetched cell.
   logic [15:0]       mem [NCELLS];
   logic [15:0]       rdata_ff;
   logic              we, re;
   logic [AW-1:0]     waddr, raddr;
   logic [15:0]       wdata;

   state_type         state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   tmce_pkg::cmd_type cmd_ff, cmd_in;
   logic              sc_ff, sc_in;
   logic              rej_ff, rej_in;
   logic              rd_wait_ff, rd_wait_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [7:0]        clear_attr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [tmce_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [AW-1:0]     cur_addr;
   logic              last_col, last_row;
   logic [CW-1:0]     col_next;
   logic              load;
   logic [15:0]       cell_word;

   function automatic logic tab_aligned(input logic [CW-1:0] c);
      logic r;
      r = 1'b0;
      for (int k = 0; k < COLS; k++) begin
         if (c == CW'(k)) begin
            r = ((k % TAB_STOP) == 0);
         end
      end
      return r;
   endfunction

   assign cur_addr  = AW'(32'(row_ff) * COLS + 32'(col_ff));
   assign last_col  = (col_ff == CW'(COLS - 1));
   assign last_row  = (row_ff == RW'(ROWS - 1));
   assign col_next  = last_col ? '0 : col_ff + 1'b1;
   assign cell_word = rd_wait_ff ? rdata_ff : 16'h0000;
   assign load      = (state_ff == S_DONE) && !rd_wait_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cmd_in       = cmd_ff;
      sc_in        = sc_ff;
      rej_in       = rej_ff;
      rd_wait_in   = 1'b0;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = cur_addr;
      wdata        = 16'h0000;
      re           = 1'b0;
      raddr        = AW'(cmd_ff.ridx);
      unique case (state_ff)
         S_INIT: begin
            we    = 1'b1;
            waddr = cnt_ff;
            if (cnt_ff == AW'(NCELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_out.cmd;
               sc_in    = 1'b0;
               rej_in   = 1'b0;
               cnt_in   = '0;
               state_in = S_DONE;
               case (q_out.cmd.kind) inside
                  tmce_pkg::K_PRINT, tmce_pkg::K_TAB: state_in = S_PRINT;
                  tmce_pkg::K_BKSP: begin
                     if (col_ff != '0 || row_ff != '0) begin
                        if (col_ff == '0) begin
                           row_in = row_ff - 1'b1;
                           col_in = CW'(COLS - 1);
                        end else begin
                           col_in = col_ff - 1'b1;
                        end
                        state_in = S_BKWR;
                     end
                  end
                  tmce_pkg::K_NEWLINE: begin
                     col_in = '0;
                     if (last_row) begin
                        sc_in    = 1'b1;
                        state_in = S_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  tmce_pkg::K_RETURN: col_in = '0;
                  tmce_pkg::K_CLEAR:  state_in = S_CLEAR;
                  tmce_pkg::K_SETCUR: begin
                     col_in = CW'(q_out.cmd.tcol);
                     row_in = RW'(q_out.cmd.trow);
                  end
                  tmce_pkg::K_REJECT: rej_in = 1'b1;
                  tmce_pkg::K_READ: begin
                     re         = 1'b1;
                     raddr      = AW'(q_out.cmd.ridx);
                     rd_wait_in = 1'b1;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_PRINT: begin
            we     = 1'b1;
            wdata  = {cmd_ff.attr,
                      (cmd_ff.kind == tmce_pkg::K_TAB) ? tmce_pkg::CH_SPACE : cmd_ff.ch};
            col_in = col_next;
            if (last_col && last_row) begin
               sc_in    = 1'b1;
               state_in = S_SCROLL;
            end else begin
               if (last_col) begin
                  row_in = row_ff + 1'b1;
               end
               if (cmd_ff.kind == tmce_pkg::K_TAB && !tab_aligned(col_next)) begin
                  state_in = S_PRINT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_BKWR: begin
            we       = 1'b1;
            wdata    = {cmd_ff.attr, tmce_pkg::CH_SPACE};
            state_in = S_DONE;
         end
         S_SCROLL: begin
            // Reads run ahead of the writes that move each cell up a row; the read data is registered in rdata_ff.
            we    = pend_ff;
            waddr = pend_addr_ff;
            wdata = rdata_ff;
            if (32'(cnt_ff) < COPY_N) begin
               re           = 1'b1;
               raddr        = AW'(32'(cnt_ff) + COLS);
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in       = cnt_ff + 1'b1;
            end else begin
               state_in = S_SCRCLR;
            end
         end
         S_SCRCLR: begin
            we    = 1'b1;
            waddr = cnt_ff;
            if (cnt_ff == AW'(NCELLS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            we    = 1'b1;
            waddr = cnt_ff;
            wdata = {clear_attr_ff, tmce_pkg::CH_SPACE};
            if (cnt_ff == AW'(NCELLS - 1)) begin
               col_in   = '0;
               row_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rd_wait_ff) begin
               // Hold the fetched cell until the result register is free.
               rd_wait_in = !(!rsp_valid_ff || rsp_tready);
            end
            if (!rd_wait_ff || !rd_wait_in) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load || (state_ff == S_DONE && rd_wait_ff && (!rsp_valid_ff || rsp_tready))) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, rej_ff, sc_ff, cell_word[15:8], cell_word[7:0],
                         11'(32'(row_ff) * COLS + 32'(col_ff)), 5'(row_ff), 7'(col_ff)};
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         rd_wait_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         clear_attr_ff <= 8'd7;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         rd_wait_ff <= rd_wait_in;
         pend_ff    <= pend_in;
         if (csr_valid) begin
            clear_attr_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sc_ff        <= sc_in;
      rej_ff       <= rej_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/tmce_checker.sv
module tmce_checker #(
   parameter int COLS = 80
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tmce_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[40] |-> !rsp_tdata[39] && rsp_tdata[38:23] == 16'h0000)
      else $error("rejected word carries scroll or cell data");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[6:0]) < COLS)
      else $error("cursor column out of range");

endmodule

bind text_mode_console_engine_unit tmce_checker #(.COLS(COLS)) u_tmce_checker (.*);

>>> bench/tb_top.sv
module tb_top;

   localparam int NCOLS = 80;
   localparam int NROWS = 25;
   localparam int NCELLS = NCOLS * NROWS;
   localparam int TABW = 4;

   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] offset;
      logic [7:0]  cchar;
      logic [7:0]  cattr;
      logic        scrolled;
      logic        rejected;
   } console_rsp_type;

   // Predicts the console state and holds the cursor reports still due.
   class console_scoreboard_type;
      logic [15:0]     cells[NCELLS];
      int              ccol, crow;
      logic [7:0]      clr_attr;
      console_rsp_type pending[$];
      int              errors, n_in, n_out, n_scroll;

      function void init();
         foreach (cells[i]) cells[i] = '0;
         ccol = 0;
         crow = 0;
         clr_attr = 8'd7;
      endfunction

      function bit scroll_up();
         if (crow < NROWS) return 0;
         for (int i = 0; i < NCELLS - NCOLS; i++) cells[i] = cells[i + NCOLS];
         for (int i = NCELLS - NCOLS; i < NCELLS; i++) cells[i] = '0;
         crow = NROWS - 1;
         return 1;
      endfunction

      function bit emit(logic [7:0] ch, logic [7:0] at);
         cells[crow * NCOLS + ccol] = {at, ch};
         ccol++;
         if (ccol >= NCOLS) begin
            ccol = 0;
            crow++;
         end
         return scroll_up();
      endfunction

      function void note_request(logic [1:0] kind, logic [39:0] d);
         logic [7:0]      ch;
         logic [7:0]      at;
         logic [6:0]      tcol;
         logic [4:0]      trow;
         logic [10:0]     ridx;
         console_rsp_type r;
         ch = d[7:0];
         at = {d[11:8], d[15:12]};
         tcol = d[22:16];
         trow = d[27:23];
         ridx = d[38:28];
         r = '0;
         n_in++;
         case (kind)
            tmce_pkg::REQ_PUT: begin
               if (ch == tmce_pkg::CH_BACKSPACE) begin
                  if (ccol != 0 || crow != 0) begin
                     if (ccol == 0) begin
                        crow--;
                        ccol = NCOLS - 1;
                     end else begin
                        ccol--;
                     end
                     cells[crow * NCOLS + ccol] = {at, tmce_pkg::CH_SPACE};
                  end
               end else if (ch == tmce_pkg::CH_NEWLINE) begin
                  ccol = 0;
                  crow++;
                  r.scrolled = scroll_up();
               end else if (ch == tmce_pkg::CH_RETURN) begin
                  ccol = 0;
               end else if (ch == tmce_pkg::CH_TAB) begin
                  do begin
                     if (emit(tmce_pkg::CH_SPACE, at)) r.scrolled = 1;
                  end while (ccol % TABW != 0);
               end else begin
                  r.scrolled = emit(ch, at);
               end
            end
            tmce_pkg::REQ_CLEAR: begin
               foreach (cells[i]) cells[i] = {clr_attr, tmce_pkg::CH_SPACE};
               ccol = 0;
               crow = 0;
            end
            tmce_pkg::REQ_SETC: begin
               if (tcol < NCOLS && trow < NROWS) begin
                  ccol = tcol;
                  crow = trow;
               end else begin
                  r.rejected = 1;
               end
            end
            default: begin
               if (ridx < NCELLS) {r.cattr, r.cchar} = cells[ridx];
            end
         endcase
         if (r.scrolled) n_scroll++;
         r.col = 7'(ccol);
         r.row = 5'(crow);
         r.offset = 11'(crow * NCOLS + ccol);
         pending.push_back(r);
      endfunction

      function void check_response(logic [47:0] d);
         console_rsp_type got, exp;
         got = {d[6:0], d[11:7], d[22:12], d[30:23], d[38:31], d[39], d[40]};
         n_out++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, d);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.col != exp.col)
            $display("%0t: cursor_col exp %0d got %0d", $time, exp.col, got.col);
         if (got.row != exp.row)
            $display("%0t: cursor_row exp %0d got %0d", $time, exp.row, got.row);
         if (got.offset != exp.offset)
            $display("%0t: cursor_offset exp %0d got %0d", $time, exp.offset, got.offset);
         if (got.cchar != exp.cchar)
            $display("%0t: cell_char exp %h got %h", $time, exp.cchar, got.cchar);
         if (got.cattr != exp.cattr)
            $display("%0t: cell_attr exp %h got %h", $time, exp.cattr, got.cattr);
         if (got.scrolled != exp.scrolled)
            $display("%0t: scrolled exp %b got %b", $time, exp.scrolled, got.scrolled);
         if (got.rejected != exp.rejected)
            $display("%0t: rejected exp %b got %b", $time, exp.rejected, got.rejected);
         if (got != exp) errors++;
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_data;

   console_scoreboard_type board;
   bit hold_rsp;
   int rsp_gap_max;

   text_mode_console_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, or a long hold while hold_rsp is set.
   initial begin
      int gap;
      rsp_tready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
            if (gap != 0) begin
               rsp_tready <= 0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_response(rsp_tdata);
      end
   end

   task automatic send_word(logic [1:0] kind, logic [39:0] d, int gap_max);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, d);
   endtask

   task automatic send_req(logic [1:0] kind, int ch, int bk, int fg,
                           int tc, int tr, int ri, int gap_max);
      send_word(kind, {1'b0, 11'(ri), 5'(tr), 7'(tc), 4'(fg), 4'(bk), 8'(ch)}, gap_max);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_attr(logic [7:0] v);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      board.clr_attr = v;
   endtask

   function automatic int pick_char();
      case ($urandom_range(0, 9))
         0: return tmce_pkg::CH_BACKSPACE;
         1: return tmce_pkg::CH_NEWLINE;
         2: return tmce_pkg::CH_RETURN;
         3: return tmce_pkg::CH_TAB;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic random_req(int gap_max);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         send_req(tmce_pkg::REQ_PUT, pick_char(), $urandom, $urandom, $urandom, $urandom,
                  $urandom, gap_max);
      else if (sel < 72)
         send_req(tmce_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, gap_max);
      else if (sel < 84)
         send_req(tmce_pkg::REQ_SETC, $urandom, $urandom, $urandom,
                  $urandom_range(0, 3) ? $urandom_range(0, 79) : $urandom_range(0, 127),
                  $urandom_range(0, 3) ? $urandom_range(0, 24) : $urandom_range(0, 31),
                  $urandom, gap_max);
      else
         send_req(tmce_pkg::REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 9) ? $urandom_range(0, 1999) : $urandom_range(0, 2047),
                  gap_max);
   endtask

   initial begin
      logic [7:0] attrs[5];
      board = new();
      board.init();
      rsp_gap_max = 14;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = tmce_pkg::REQ_PUT;
      csr_valid = 0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: corner backspace, reads of unwritten cells, controls, extremes.
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_BACKSPACE, 4'hF, 4'hF, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_READ, 0, 0, 0, 0, 0, 11'd1999, 3);
      send_req(tmce_pkg::REQ_READ, 0, 0, 0, 0, 0, 11'd2047, 3);
      send_req(tmce_pkg::REQ_PUT, 8'hFF, 4'hF, 4'h0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_PUT, 8'h00, 4'h0, 4'hF, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_TAB, 4'hA, 4'h5, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_RETURN, 0, 0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_NEWLINE, 0, 0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_BACKSPACE, 4'h3, 4'hC, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_SETC, 0, 0, 0, 7'd79, 5'd24, 0, 3);
      send_req(tmce_pkg::REQ_PUT, 8'h41, 1, 2, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_SETC, 0, 0, 0, 7'd127, 5'd0, 0, 3);
      send_req(tmce_pkg::REQ_SETC, 0, 0, 0, 7'd0, 5'd31, 0, 3);
      send_req(tmce_pkg::REQ_SETC, 0, 0, 0, 7'd78, 5'd24, 0, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_TAB, 4'h7, 4'h1, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_SETC, 0, 0, 0, 7'd0, 5'd24, 0, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_NEWLINE, 0, 0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_READ, 0, 0, 0, 0, 0, 11'd1919, 3);
      send_req(tmce_pkg::REQ_PUT, tmce_pkg::CH_BACKSPACE, 0, 0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 3);
      send_req(tmce_pkg::REQ_READ, 0, 0, 0, 0, 0, 11'd1234, 3);
      drain();

      // Sender pressure while the receiver holds off.
      hold_rsp = 1;
      repeat (12) send_req(tmce_pkg::REQ_PUT, $urandom_range(32, 126), $urandom, $urandom,
                           0, 0, 0, 0);
      drain();

      attrs = '{8'h00, 8'hFF, 8'h1E, 8'h70, 8'h07};
      foreach (attrs[p]) begin
         write_attr(attrs[p]);
         send_req(tmce_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 2);
         for (int i = 0; i < 140; i++) begin
            // Some stretches run without any idling on either side.
            rsp_gap_max = (i % 50 < 15) ? 0 : 14;
            random_req((i % 50 < 15) ? 0 : 14);
         end
         drain();
      end

      $display("Sent %0d requests, checked %0d responses, %0d of them scrolled.",
               board.n_in, board.n_out, board.n_scroll);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
